// ----- hw/rtl/vcsp_pkg.sv -----
package vcsp_pkg;

  localparam int COUNT_BITS = 32;
  localparam int FIFO_DEPTH = 3;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] OP_END        = 8'h66;
  localparam logic [7:0] OP_REG_WRITE  = 8'hB3;
  localparam logic [7:0] OP_WAIT_N     = 8'h61;
  localparam logic [7:0] OP_WAIT_735   = 8'h62;
  localparam logic [7:0] OP_WAIT_882   = 8'h63;
  localparam logic [7:0] OP_SHORT_LO   = 8'h70;
  localparam logic [7:0] OP_SHORT_HI   = 8'h7F;
  localparam logic [7:0] MISSING_BYTE  = 8'hFF;
  localparam logic [15:0] WAIT_735     = 16'd735;
  localparam logic [15:0] WAIT_882     = 16'd882;

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_WAIT    = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_ENDED   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  opcode;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
    logic [15:0] wait_samples;
    logic [31:0] command_index;
    logic [31:0] write_total;
    logic [31:0] wait_total;
    logic [31:0] first_write_index;
    logic        first_write_seen;
    logic        last_of_run;
  } result_t;

  // up to two results per input transfer, in order r0 then r1
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

endpackage

// ----- hw/rtl/vgm_command_stream_parser.sv -----
// command stream parser for a sound-log byte stream
// input channel: one stream byte (or an end-of-input marker) per transfer,
//   in_valid_i / in_ready_o, payload in_data_i
// output channel: one decoded command result per transfer,
//   out_valid_o / out_ready_i, payload out_data_o
// operand bytes give no result; a complete command gives one result, and an
//   end-of-input transfer gives up to two (pending command, then input ended)
// a result is written into the result queue by the transfer that completes it
// throughput: one input transfer per cycle sustained while results are taken,
//   set by the phase update and a three-entry result queue
// in_ready_o drops while the result queue holds two or more results, so a
//   stalled receiver backs up into the input after two results are waiting
// reset: phase returns to awaiting an opcode, all counts clear, the result
//   queue empties; after the end command or end of input, all further
//   transfers are taken and dropped until reset
module vgm_command_stream_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vcsp_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vcsp_pkg::result_t out_data_o
);

  logic            in_fire;
  logic            room2;
  vcsp_pkg::push_t push;

  assign in_ready_o = room2;
  assign in_fire    = in_valid_i && in_ready_o;

  // phase tracking, field decode and running counts
  vcsp_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  // result queue, doubles as output register
  vcsp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // a double result is always a pending command followed by input ended
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.num == 2'd2 |-> (push.r1.kind == vcsp_pkg::KIND_ENDED && !push.r0.last_of_run))
    else $error("double result out of order");

  // a single result is the last one of its input transfer
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.num == 2'd1 |-> push.r0.last_of_run)
    else $error("single result not marked last");

  // results only come from accepted input transfers
  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.num != 2'd0 |-> in_fire)
    else $error("result without input transfer");

  // a result that is offered stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output dropped while stalled");
`endif

endmodule

// ----- hw/rtl/vcsp_decoder.sv -----
module vcsp_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  vcsp_pkg::in_item_t in_data_i,
  output vcsp_pkg::push_t    push_o
);

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_WR_REG  = 3'd1,
    PH_WR_DATA = 3'd2,
    PH_WT_LO   = 3'd3,
    PH_WT_HI   = 3'd4
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [7:0]                      opcode_q, opcode_d;
  logic [7:0]                      operand_q, operand_d;
  logic                            finished_q, finished_d;
  logic [vcsp_pkg::COUNT_BITS-1:0] cmd_cnt_q, cmd_cnt_d;
  logic [vcsp_pkg::COUNT_BITS-1:0] wr_cnt_q, wr_cnt_d;
  logic [vcsp_pkg::COUNT_BITS-1:0] wt_cnt_q, wt_cnt_d;
  logic [vcsp_pkg::COUNT_BITS-1:0] fw_pos_q, fw_pos_d;
  logic                            fw_flag_q, fw_flag_d;

  logic              cmd_fire;
  vcsp_pkg::kind_e   cmd_kind;
  logic [7:0]        cmd_op, cmd_ra, cmd_rv;
  logic [15:0]       cmd_ws;
  logic              end_cmd;
  logic              ended;
  logic [7:0]        b;
  vcsp_pkg::result_t r_cmd, r_end;

  assign b = in_data_i.data_byte;

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    operand_d  = operand_q;
    finished_d = finished_q;
    cmd_fire   = 1'b0;
    cmd_kind   = vcsp_pkg::KIND_UNKNOWN;
    cmd_op     = opcode_q;
    cmd_ra     = '0;
    cmd_rv     = '0;
    cmd_ws     = '0;
    end_cmd    = 1'b0;
    ended      = 1'b0;
    if (!finished_q) begin
      if (in_data_i.end_of_input) begin
        ended      = 1'b1;
        phase_d    = PH_OPCODE;
        finished_d = 1'b1;
        unique case (phase_q)
          PH_WR_REG: begin
            cmd_fire = 1'b1;
            cmd_kind = vcsp_pkg::KIND_WRITE;
            cmd_ra   = vcsp_pkg::MISSING_BYTE;
            cmd_rv   = vcsp_pkg::MISSING_BYTE;
          end
          PH_WR_DATA: begin
            cmd_fire = 1'b1;
            cmd_kind = vcsp_pkg::KIND_WRITE;
            cmd_ra   = operand_q;
            cmd_rv   = vcsp_pkg::MISSING_BYTE;
          end
          PH_WT_LO: begin
            cmd_fire = 1'b1;
            cmd_kind = vcsp_pkg::KIND_WAIT;
            cmd_ws   = {vcsp_pkg::MISSING_BYTE, vcsp_pkg::MISSING_BYTE};
          end
          PH_WT_HI: begin
            cmd_fire = 1'b1;
            cmd_kind = vcsp_pkg::KIND_WAIT;
            cmd_ws   = {vcsp_pkg::MISSING_BYTE, operand_q};
          end
          default: ;
        endcase
      end else begin
        unique case (phase_q)
          PH_WR_REG: begin
            operand_d = b;
            phase_d   = PH_WR_DATA;
          end
          PH_WR_DATA: begin
            phase_d  = PH_OPCODE;
            cmd_fire = 1'b1;
            cmd_kind = vcsp_pkg::KIND_WRITE;
            cmd_ra   = operand_q;
            cmd_rv   = b;
          end
          PH_WT_LO: begin
            operand_d = b;
            phase_d   = PH_WT_HI;
          end
          PH_WT_HI: begin
            phase_d  = PH_OPCODE;
            cmd_fire = 1'b1;
            cmd_kind = vcsp_pkg::KIND_WAIT;
            cmd_ws   = {b, operand_q};
          end
          default: begin
            // unused phase codes behave as awaiting an opcode
            phase_d = PH_OPCODE;
            cmd_op  = b;
            if (b == vcsp_pkg::OP_END) begin
              end_cmd    = 1'b1;
              finished_d = 1'b1;
            end else if (b == vcsp_pkg::OP_REG_WRITE) begin
              opcode_d = b;
              phase_d  = PH_WR_REG;
            end else if (b == vcsp_pkg::OP_WAIT_N) begin
              opcode_d = b;
              phase_d  = PH_WT_LO;
            end else if (b == vcsp_pkg::OP_WAIT_735) begin
              cmd_fire = 1'b1;
              cmd_kind = vcsp_pkg::KIND_WAIT;
              cmd_ws   = vcsp_pkg::WAIT_735;
            end else if (b == vcsp_pkg::OP_WAIT_882) begin
              cmd_fire = 1'b1;
              cmd_kind = vcsp_pkg::KIND_WAIT;
              cmd_ws   = vcsp_pkg::WAIT_882;
            end else if (b >= vcsp_pkg::OP_SHORT_LO && b <= vcsp_pkg::OP_SHORT_HI) begin
              cmd_fire = 1'b1;
              cmd_kind = vcsp_pkg::KIND_WAIT;
              cmd_ws   = {12'd0, b[3:0]} + 16'd1;
            end else begin
              cmd_fire = 1'b1;
              cmd_kind = vcsp_pkg::KIND_UNKNOWN;
            end
          end
        endcase
      end
    end
  end

  // running counts after the completed command
  always_comb begin
    cmd_cnt_d = cmd_cnt_q;
    wr_cnt_d  = wr_cnt_q;
    wt_cnt_d  = wt_cnt_q;
    fw_pos_d  = fw_pos_q;
    fw_flag_d = fw_flag_q;
    if (cmd_fire) begin
      cmd_cnt_d = vcsp_pkg::sat_inc(cmd_cnt_q);
      if (cmd_kind == vcsp_pkg::KIND_WRITE) begin
        wr_cnt_d = vcsp_pkg::sat_inc(wr_cnt_q);
        if (!fw_flag_q) begin
          fw_flag_d = 1'b1;
          fw_pos_d  = cmd_cnt_q;
        end
      end else if (cmd_kind == vcsp_pkg::KIND_WAIT) begin
        wt_cnt_d = vcsp_pkg::sat_inc(wt_cnt_q);
      end
    end
  end

  always_comb begin
    r_cmd.kind              = cmd_kind;
    r_cmd.opcode            = cmd_op;
    r_cmd.reg_addr          = cmd_ra;
    r_cmd.reg_value         = cmd_rv;
    r_cmd.wait_samples      = cmd_ws;
    r_cmd.command_index     = 32'(cmd_cnt_q);
    r_cmd.write_total       = 32'(wr_cnt_d);
    r_cmd.wait_total        = 32'(wt_cnt_d);
    r_cmd.first_write_index = fw_flag_d ? 32'(fw_pos_d) : 32'd0;
    r_cmd.first_write_seen  = fw_flag_d;
    r_cmd.last_of_run       = !ended;

    r_end                   = r_cmd;
    r_end.kind              = ended ? vcsp_pkg::KIND_ENDED : vcsp_pkg::KIND_END;
    r_end.opcode            = ended ? 8'd0 : b;
    r_end.reg_addr          = '0;
    r_end.reg_value         = '0;
    r_end.wait_samples      = '0;
    r_end.command_index     = 32'(cmd_cnt_d);
    r_end.last_of_run       = 1'b1;
  end

  always_comb begin
    push_o.num = 2'd0;
    push_o.r0  = cmd_fire ? r_cmd : r_end;
    push_o.r1  = r_end;
    if (in_fire_i) begin
      if (cmd_fire && ended) begin
        push_o.num = 2'd2;
      end else if (cmd_fire || ended || end_cmd) begin
        push_o.num = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_OPCODE;
      opcode_q   <= '0;
      operand_q  <= '0;
      finished_q <= 1'b0;
      cmd_cnt_q  <= '0;
      wr_cnt_q   <= '0;
      wt_cnt_q   <= '0;
      fw_pos_q   <= '0;
      fw_flag_q  <= 1'b0;
    end else if (in_fire_i) begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      operand_q  <= operand_d;
      finished_q <= finished_d;
      cmd_cnt_q  <= cmd_cnt_d;
      wr_cnt_q   <= wr_cnt_d;
      wt_cnt_q   <= wt_cnt_d;
      fw_pos_q   <= fw_pos_d;
      fw_flag_q  <= fw_flag_d;
    end
  end

endmodule

// ----- hw/rtl/vcsp_out_fifo.sv -----
module vcsp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vcsp_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              room2_o,
  output logic              valid_o,
  output vcsp_pkg::result_t data_o
);

  vcsp_pkg::result_t                 mem_q [vcsp_pkg::FIFO_DEPTH];
  logic [vcsp_pkg::PTR_BITS-1:0]     head_q, head_d;
  logic [vcsp_pkg::PTR_BITS-1:0]     tail_q, tail_d;
  logic [vcsp_pkg::CNT_BITS-1:0]     cnt_q, cnt_d;
  logic [vcsp_pkg::PTR_BITS-1:0]     tail_p1;

  assign tail_p1 = vcsp_pkg::ptr_inc(tail_q);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[head_q];
  // two free entries are needed for the worst-case transfer
  assign room2_o = (cnt_q <= vcsp_pkg::CNT_BITS'(vcsp_pkg::FIFO_DEPTH - 2));

  always_comb begin
    head_d = (pop_i && valid_o) ? vcsp_pkg::ptr_inc(head_q) : head_q;
    tail_d = tail_q;
    case (push_i.num)
      2'd1:    tail_d = tail_p1;
      2'd2:    tail_d = vcsp_pkg::ptr_inc(tail_p1);
      default: tail_d = tail_q;
    endcase
    cnt_d = cnt_q + vcsp_pkg::CNT_BITS'(push_i.num)
          - vcsp_pkg::CNT_BITS'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[tail_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- bench/vgm_command_stream_parser_tb.sv -----
module vgm_command_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // counts saturate at the top of their width
  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << vcsp_pkg::COUNT_BITS) - 64'd1);
  // a result is queued at the edge that takes its transfer; spare cycles follow at the end
  localparam int TAIL_CYCLES = 8;

  // where the decoder stands between bytes
  typedef enum logic [2:0] {
    AWAIT_OPCODE  = 3'd0,
    AWAIT_REG     = 3'd1,
    AWAIT_DATA    = 3'd2,
    AWAIT_WAIT_LO = 3'd3,
    AWAIT_WAIT_HI = 3'd4
  } parse_phase_e;

  // tracks the command stream as the block should see it and holds the
  // decoded results still owed by the block, oldest first
  class parse_tracker;
    parse_phase_e      phase;
    logic [7:0]        held_opcode;
    logic [7:0]        held_operand;
    bit                finished;
    logic [31:0]       command_count;
    logic [31:0]       write_count;
    logic [31:0]       wait_tally;
    logic [31:0]       first_write_pos;
    bit                first_write_flag;
    vcsp_pkg::result_t owed_results[$];
    int                errors;

    function new();
      phase            = AWAIT_OPCODE;
      held_opcode      = '0;
      held_operand     = '0;
      finished         = 1'b0;
      command_count    = '0;
      write_count      = '0;
      wait_tally       = '0;
      first_write_pos  = '0;
      first_write_flag = 1'b0;
      errors           = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v >= COUNT_MAX) ? COUNT_MAX : v + 32'd1;
    endfunction

    function void push_result(vcsp_pkg::kind_e kind, logic [7:0] op, logic [7:0] ra,
                              logic [7:0] rv, logic [15:0] ws, logic [31:0] idx, bit last);
      vcsp_pkg::result_t r;
      r.kind              = kind;
      r.opcode            = op;
      r.reg_addr          = ra;
      r.reg_value         = rv;
      r.wait_samples      = ws;
      r.command_index     = idx;
      r.write_total       = write_count;
      r.wait_total        = wait_tally;
      r.first_write_index = first_write_flag ? first_write_pos : '0;
      r.first_write_seen  = first_write_flag;
      r.last_of_run       = last;
      owed_results.push_back(r);
    endfunction

    // a counted command: write, wait or unknown
    function void complete(vcsp_pkg::kind_e kind, logic [7:0] op, logic [7:0] ra,
                           logic [7:0] rv, logic [15:0] ws, bit last);
      logic [31:0] idx;
      idx = command_count;
      if (kind == vcsp_pkg::KIND_WRITE) begin
        write_count = bump(write_count);
        if (!first_write_flag) begin
          first_write_flag = 1'b1;
          first_write_pos  = idx;
        end
      end else if (kind == vcsp_pkg::KIND_WAIT) begin
        wait_tally = bump(wait_tally);
      end
      command_count = bump(command_count);
      push_result(kind, op, ra, rv, ws, idx, last);
    endfunction

    function void note_item(vcsp_pkg::in_item_t it);
      logic [7:0] b;
      b = it.data_byte;
      if (finished) return;
      if (it.end_of_input) begin
        // a pending command is closed with its missing bytes read as all ones
        case (phase)
          AWAIT_REG: complete(vcsp_pkg::KIND_WRITE, held_opcode, vcsp_pkg::MISSING_BYTE,
                              vcsp_pkg::MISSING_BYTE, '0, 1'b0);
          AWAIT_DATA: complete(vcsp_pkg::KIND_WRITE, held_opcode, held_operand,
                               vcsp_pkg::MISSING_BYTE, '0, 1'b0);
          AWAIT_WAIT_LO: complete(vcsp_pkg::KIND_WAIT, held_opcode, '0, '0,
                                  {vcsp_pkg::MISSING_BYTE, vcsp_pkg::MISSING_BYTE}, 1'b0);
          AWAIT_WAIT_HI: complete(vcsp_pkg::KIND_WAIT, held_opcode, '0, '0,
                                  {vcsp_pkg::MISSING_BYTE, held_operand}, 1'b0);
          default: ;
        endcase
        push_result(vcsp_pkg::KIND_ENDED, '0, '0, '0, '0, command_count, 1'b1);
        phase    = AWAIT_OPCODE;
        finished = 1'b1;
        return;
      end
      case (phase)
        AWAIT_REG: begin
          held_operand = b;
          phase        = AWAIT_DATA;
        end
        AWAIT_DATA: begin
          phase = AWAIT_OPCODE;
          complete(vcsp_pkg::KIND_WRITE, held_opcode, held_operand, b, '0, 1'b1);
        end
        AWAIT_WAIT_LO: begin
          held_operand = b;
          phase        = AWAIT_WAIT_HI;
        end
        AWAIT_WAIT_HI: begin
          phase = AWAIT_OPCODE;
          complete(vcsp_pkg::KIND_WAIT, held_opcode, '0, '0, {b, held_operand}, 1'b1);
        end
        default: begin
          phase = AWAIT_OPCODE;
          if (b == vcsp_pkg::OP_END) begin
            push_result(vcsp_pkg::KIND_END, b, '0, '0, '0, command_count, 1'b1);
            finished = 1'b1;
          end else if (b == vcsp_pkg::OP_REG_WRITE) begin
            held_opcode = b;
            phase       = AWAIT_REG;
          end else if (b == vcsp_pkg::OP_WAIT_N) begin
            held_opcode = b;
            phase       = AWAIT_WAIT_LO;
          end else if (b == vcsp_pkg::OP_WAIT_735) begin
            complete(vcsp_pkg::KIND_WAIT, b, '0, '0, vcsp_pkg::WAIT_735, 1'b1);
          end else if (b == vcsp_pkg::OP_WAIT_882) begin
            complete(vcsp_pkg::KIND_WAIT, b, '0, '0, vcsp_pkg::WAIT_882, 1'b1);
          end else if (b >= vcsp_pkg::OP_SHORT_LO && b <= vcsp_pkg::OP_SHORT_HI) begin
            complete(vcsp_pkg::KIND_WAIT, b, '0, '0,
                     16'(b - vcsp_pkg::OP_SHORT_LO) + 16'd1, 1'b1);
          end else begin
            complete(vcsp_pkg::KIND_UNKNOWN, b, '0, '0, '0, 1'b1);
          end
        end
      endcase
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(vcsp_pkg::result_t got);
      vcsp_pkg::result_t want;
      bit                ok;
      if (owed_results.size() == 0) begin
        $display("%0t: result with none expected, actual kind %0d opcode %0h", $time,
                 got.kind, got.opcode);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      ok = 1'b1;
      ok &= field_ok("kind", 32'(want.kind), 32'(got.kind));
      ok &= field_ok("opcode", 32'(want.opcode), 32'(got.opcode));
      ok &= field_ok("reg_addr", 32'(want.reg_addr), 32'(got.reg_addr));
      ok &= field_ok("reg_value", 32'(want.reg_value), 32'(got.reg_value));
      ok &= field_ok("wait_samples", 32'(want.wait_samples), 32'(got.wait_samples));
      ok &= field_ok("command_index", want.command_index, got.command_index);
      ok &= field_ok("write_total", want.write_total, got.write_total);
      ok &= field_ok("wait_total", want.wait_total, got.wait_total);
      ok &= field_ok("first_write_index", want.first_write_index, got.first_write_index);
      ok &= field_ok("first_write_seen", 32'(want.first_write_seen), 32'(got.first_write_seen));
      ok &= field_ok("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      if (!ok) errors++;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  vcsp_pkg::in_item_t in_data = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b1;
  vcsp_pkg::result_t  out_data_o;

  parse_tracker tracker;
  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int sent_count = 0;      // accepted input transfers

  vgm_command_stream_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver ready changes on the falling edge only
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // every output transfer is checked against the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) tracker.check_result(out_data_o);
  end

  // one input transfer; entered and left just after a falling edge
  task automatic send_item(input logic [7:0] b, input bit eoi);
    // random idle cycles ahead of the item, valid low
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_input: eoi};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // transfer taken at this edge
    tracker.note_item(in_data);
    sent_count++;
    @(negedge clk_i);
  endtask

  // one well-formed command with random content; never the end command
  task automatic send_command();
    int         pick;
    logic [7:0] noise;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_item(vcsp_pkg::OP_REG_WRITE, 1'b0);
      send_item(8'($urandom_range(255)), 1'b0);
      send_item(8'($urandom_range(255)), 1'b0);
    end else if (pick < 45) begin
      send_item(vcsp_pkg::OP_WAIT_N, 1'b0);
      send_item(8'($urandom_range(255)), 1'b0);
      send_item(8'($urandom_range(255)), 1'b0);
    end else if (pick < 50) begin
      send_item(vcsp_pkg::OP_WAIT_735, 1'b0);
    end else if (pick < 55) begin
      send_item(vcsp_pkg::OP_WAIT_882, 1'b0);
    end else if (pick < 75) begin
      send_item(vcsp_pkg::OP_SHORT_LO + 8'($urandom_range(15)), 1'b0);
    end else begin
      // noise byte as an opcode; multi-byte openers and the end are left out
      // so that the stream stays aligned on command boundaries
      do noise = 8'($urandom_range(255));
      while (noise == vcsp_pkg::OP_END || noise == vcsp_pkg::OP_REG_WRITE ||
             noise == vcsp_pkg::OP_WAIT_N);
      send_item(noise, 1'b0);
    end
  endtask

  // sender holds off until every owed result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i);
    while (tracker.owed_results.size() != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent_count < target) send_command();
    drain();
  endtask

  initial begin
    tracker = new();
    // reset held from the start, released on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: fixed and short waits at both ends of the range
    send_item(vcsp_pkg::OP_WAIT_735, 1'b0);
    send_item(vcsp_pkg::OP_WAIT_882, 1'b0);
    send_item(vcsp_pkg::OP_SHORT_LO, 1'b0);
    send_item(vcsp_pkg::OP_SHORT_HI, 1'b0);
    // 16-bit waits with all-zero and all-one operands
    send_item(vcsp_pkg::OP_WAIT_N, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(vcsp_pkg::OP_WAIT_N, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    // first register write lands at a nonzero index, then a second one
    send_item(vcsp_pkg::OP_REG_WRITE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(vcsp_pkg::OP_REG_WRITE, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    // unknown commands at the byte extremes
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // end and opener codes as operands are plain data
    send_item(vcsp_pkg::OP_REG_WRITE, 1'b0);
    send_item(vcsp_pkg::OP_END, 1'b0);
    send_item(vcsp_pkg::OP_END, 1'b0);
    send_item(vcsp_pkg::OP_WAIT_N, 1'b0);
    send_item(vcsp_pkg::OP_END, 1'b0);
    send_item(vcsp_pkg::OP_REG_WRITE, 1'b0);
    drain();

    // random: free flow, slow sender, slow receiver, both a little idle
    run_phase(0, 0, 475);
    run_phase(57, 0, 925);
    run_phase(0, 57, 1375);
    run_phase(8, 8, 1825);

    // the stream can close only once per reset; the seed picks how
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    case ($urandom_range(5))
      0: send_item(vcsp_pkg::OP_END, 1'b0);
      1: send_item(8'($urandom_range(255)), 1'b1);
      2: begin
        send_item(vcsp_pkg::OP_REG_WRITE, 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
      3: begin
        send_item(vcsp_pkg::OP_REG_WRITE, 1'b0);
        send_item(8'($urandom_range(255)), 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
      4: begin
        send_item(vcsp_pkg::OP_WAIT_N, 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
      default: begin
        send_item(vcsp_pkg::OP_WAIT_N, 1'b0);
        send_item(8'($urandom_range(255)), 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
    endcase

    // once finished, everything is taken and dropped
    send_item(vcsp_pkg::OP_END, 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
    send_item(vcsp_pkg::OP_WAIT_735, 1'b0);
    repeat (4) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));

    // wrap up: let all owed results out, then watch for strays
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (tracker.owed_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
